### design/wmf_pkg.sv
package wmf_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int MAX_HALF   = 3;

  localparam int SPAN   = 2 * MAX_HALF + 1;
  localparam int NBUF   = 2 * MAX_HALF;
  localparam int NWIN   = SPAN * SPAN;
  localparam int NLO    = (NWIN + 1) / 2;
  localparam int NHI    = NWIN - NLO;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int LW_W   = COL_W + 1;
  localparam int FH_W   = ROW_W + 1;
  localparam int HALF_W = $clog2(MAX_HALF + 1);
  localparam int RANK_W = $clog2(NWIN + 1);
  localparam int CNT_W  = $clog2(NLO + 1);
  localparam int CFG_W  = FH_W;

  localparam int OUT_BITS = 8 + ROW_W + COL_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [1:0] {
    REG_LINE_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_HALF_WIDTH   = 2'd2,
    REG_HALF_HEIGHT  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } meta_t;

endpackage

### design/window_median_filter.sv
// Streaming 2-D median filter over an 8-bit grayscale raster.
// Input channel s_*: one pixel per item in tdata[7:0], tuser[0] marks the
// first pixel of a frame. Output channel m_*: one item per interior pixel
// whose whole window lies in the frame; tdata holds the median, the center
// row and the center column, tlast marks the last result of a frame.
// The configuration port writes line width, frame height and the two
// window half sizes; write it only while the stream is idle.
// Throughput is one pixel per cycle while the receiver does not stall. From
// input accept to output valid a pixel passes the line buffer read, which
// the accepting edge loads, then the window shift, pairwise compare,
// two-level rank count and the median select into the output register.
// The line buffers are one memory of MAX_WIDTH words, each holding one
// column of the previous rows; each item reads and rewrites its column.
// A back-to-back access to the same column is forwarded around the memory.
// Reset clears the position, the pipeline valid bits and the window; the
// line buffer memory is not cleared and gets filled by the first rows.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_tready drops; it stays high whenever the output register is empty
// or is being taken in the same cycle.
module window_median_filter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] pixel
  input  logic [0:0]                    s_tuser,   // [0] frame_start
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [wmf_pkg::OUT_W-1:0]     m_tdata,   // median, center_row, center_col
  output logic                          m_tlast,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [wmf_pkg::CFG_W-1:0]     cfg_data
);

  localparam int COL_W  = wmf_pkg::COL_W;
  localparam int ROW_W  = wmf_pkg::ROW_W;
  localparam int LW_W   = wmf_pkg::LW_W;
  localparam int FH_W   = wmf_pkg::FH_W;
  localparam int HALF_W = wmf_pkg::HALF_W;
  localparam int SPAN   = wmf_pkg::SPAN;
  localparam int NBUF   = wmf_pkg::NBUF;
  localparam int NWIN   = wmf_pkg::NWIN;
  localparam int NLO    = wmf_pkg::NLO;
  localparam int RANK_W = wmf_pkg::RANK_W;
  localparam int CNT_W  = wmf_pkg::CNT_W;
  localparam int OUT_W  = wmf_pkg::OUT_W;
  localparam int BUF_W  = NBUF * 8;

  // Configuration.
  logic [LW_W-1:0]   line_width;
  logic [FH_W-1:0]   frame_height;
  logic [HALF_W-1:0] half_width;
  logic [HALF_W-1:0] half_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width   <= LW_W'(640);
      frame_height <= FH_W'(480);
      half_width   <= HALF_W'(1);
      half_height  <= HALF_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        wmf_pkg::REG_LINE_WIDTH:   line_width   <= cfg_data[LW_W-1:0];
        wmf_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
        wmf_pkg::REG_HALF_WIDTH:   half_width   <= cfg_data[HALF_W-1:0];
        wmf_pkg::REG_HALF_HEIGHT:  half_height  <= cfg_data[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  logic [LW_W-1:0]   w_eff;
  logic [FH_W-1:0]   h_eff;
  logic [HALF_W-1:0] hw_eff;
  logic [HALF_W-1:0] hh_eff;

  always_comb begin
    if (line_width == '0) w_eff = LW_W'(1);
    else if (line_width > LW_W'(wmf_pkg::MAX_WIDTH)) w_eff = LW_W'(wmf_pkg::MAX_WIDTH);
    else w_eff = line_width;
    if (frame_height == '0) h_eff = FH_W'(1);
    else if (frame_height > FH_W'(wmf_pkg::MAX_HEIGHT)) h_eff = FH_W'(wmf_pkg::MAX_HEIGHT);
    else h_eff = frame_height;
    hw_eff = (half_width > HALF_W'(wmf_pkg::MAX_HALF)) ? HALF_W'(wmf_pkg::MAX_HALF)
                                                      : half_width;
    hh_eff = (half_height > HALF_W'(wmf_pkg::MAX_HALF)) ? HALF_W'(wmf_pkg::MAX_HALF)
                                                       : half_height;
  end

  // Global pipeline enable.
  logic en;
  logic accept;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign accept   = s_tvalid && en;

  // Position of the incoming pixel.
  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] c_in;
  logic [ROW_W-1:0] r_in;
  logic [FH_W-1:0]  r_tmp;
  logic [LW_W-1:0]  c_inc;
  logic [FH_W-1:0]  r_inc;
  logic [COL_W-1:0] col_count_next;
  logic [ROW_W-1:0] row_count_next;
  logic             res_in;
  logic             last_in;

  always_comb begin
    c_in  = col_count;
    r_tmp = {1'b0, row_count};
    if (s_tuser[0]) begin
      c_in  = '0;
      r_tmp = '0;
    end else begin
      if ({1'b0, col_count} >= w_eff) begin
        c_in  = '0;
        r_tmp = r_tmp + FH_W'(1);
      end
      if (r_tmp >= h_eff) r_tmp = '0;
    end
    r_in    = r_tmp[ROW_W-1:0];
    res_in  = ({1'b0, r_in} >= FH_W'({hh_eff, 1'b0})) &&
              ({1'b0, c_in} >= LW_W'({hw_eff, 1'b0}));
    last_in = ({1'b0, r_in} == h_eff - FH_W'(1)) && ({1'b0, c_in} == w_eff - LW_W'(1));

    c_inc = {1'b0, c_in} + LW_W'(1);
    r_inc = {1'b0, r_in};
    if (c_inc >= w_eff) begin
      c_inc = '0;
      r_inc = r_inc + FH_W'(1);
      if (r_inc >= h_eff) r_inc = '0;
    end
    col_count_next = c_inc[COL_W-1:0];
    row_count_next = r_inc[ROW_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // Stage 1: line buffer read with forwarding.
  logic [BUF_W-1:0] line_mem [wmf_pkg::MAX_WIDTH];
  logic [BUF_W-1:0] rd_data;
  logic [BUF_W-1:0] wr_data;
  logic [BUF_W-1:0] fwd_data;
  logic [BUF_W-1:0] buf_cur;
  logic             fwd;
  logic             s1_valid;
  logic             s1_res;
  logic [7:0]       s1_pixel;
  logic [COL_W-1:0] s1_col;
  wmf_pkg::meta_t   s1_meta;

  always_ff @(posedge clk) begin
    if (en) begin
      rd_data  <= line_mem[c_in];
      fwd      <= s1_valid && (s1_col == c_in);
      fwd_data <= wr_data;
      s1_pixel <= s_tdata;
      s1_col   <= c_in;
      s1_res   <= res_in;
      s1_meta  <= '{row: r_in - ROW_W'(hh_eff), col: c_in - COL_W'(hw_eff), last: last_in};
    end
    if (en && s1_valid) line_mem[s1_col] <= wr_data;
  end

  assign buf_cur = fwd ? fwd_data : rd_data;
  // Row 0 of the buffer is the most recent row; the oldest falls off the top.
  assign wr_data = {buf_cur[BUF_W-9:0], s1_pixel};

  // Stage 2: the window shifts left by one column per item.
  logic [7:0]     win [SPAN][SPAN];
  logic [7:0]     new_col [SPAN];
  logic           s2_valid;
  wmf_pkg::meta_t s2_meta;

  always_comb begin
    new_col[SPAN-1] = s1_pixel;
    for (int j = 0; j < NBUF; j++) new_col[SPAN-2-j] = buf_cur[j*8 +: 8];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SPAN; i++)
        for (int j = 0; j < SPAN; j++) win[i][j] <= '0;
    end else if (en && s1_valid) begin
      for (int i = 0; i < SPAN; i++) begin
        for (int j = 0; j < SPAN - 1; j++) win[i][j] <= win[i][j+1];
        win[i][SPAN-1] <= new_col[i];
      end
    end
    if (en) s2_meta <= s1_meta;
  end

  // Selection of the active window and the target rank.
  logic [NWIN-1:0]   sel;
  logic [RANK_W-1:0] half_rank;
  logic [3:0]        ht;
  logic [3:0]        wd;
  logic [7:0]        nsel;

  always_comb begin
    for (int i = 0; i < SPAN; i++)
      for (int j = 0; j < SPAN; j++)
        sel[i*SPAN+j] = (i >= SPAN - 1 - 2 * int'(hh_eff)) &&
                        (j >= SPAN - 1 - 2 * int'(hw_eff));
    ht        = {1'b0, hh_eff, 1'b1};
    wd        = {1'b0, hw_eff, 1'b1};
    nsel      = ht * wd;
    half_rank = RANK_W'(nsel >> 1);
  end

  // Stage 3: pairwise order bits, ties broken by position.
  logic [NWIN-1:0] before_bits [NWIN];
  logic [NWIN-1:0] s3_before [NWIN];
  logic [7:0]      s3_val [NWIN];
  logic            s3_valid;
  wmf_pkg::meta_t  s3_meta;

  always_comb begin
    for (int k = 0; k < NWIN; k++)
      for (int m = 0; m < NWIN; m++)
        before_bits[k][m] = sel[m] &&
          ((win[m/SPAN][m%SPAN] < win[k/SPAN][k%SPAN]) ||
           ((win[m/SPAN][m%SPAN] == win[k/SPAN][k%SPAN]) && (m < k)));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NWIN; k++) begin
        s3_before[k] <= before_bits[k];
        s3_val[k]    <= win[k/SPAN][k%SPAN];
      end
      s3_meta <= s2_meta;
    end
  end

  // Stage 4: partial rank counts.
  logic [CNT_W-1:0] s4_lo [NWIN];
  logic [CNT_W-1:0] s4_hi [NWIN];
  logic [7:0]       s4_val [NWIN];
  logic             s4_valid;
  wmf_pkg::meta_t   s4_meta;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NWIN; k++) begin
        s4_lo[k]  <= CNT_W'($countones(s3_before[k][NLO-1:0]));
        s4_hi[k]  <= CNT_W'($countones(s3_before[k][NWIN-1:NLO]));
        s4_val[k] <= s3_val[k];
      end
      s4_meta <= s3_meta;
    end
  end

  // Stage 5: the selected element whose rank is the middle one.
  logic [7:0] med;

  always_comb begin
    med = '0;
    for (int k = 0; k < NWIN; k++)
      if (sel[k] && ((RANK_W'(s4_lo[k]) + RANK_W'(s4_hi[k])) == half_rank))
        med = med | s4_val[k];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      s1_valid <= s_tvalid;
      s2_valid <= s1_valid && s1_res;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      m_tvalid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= OUT_W'({s4_meta.col, s4_meta.row, med});
      m_tlast <= s4_meta.last;
    end
  end

endmodule

### design/wmf_checker.sv
module wmf_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [wmf_pkg::OUT_W-1:0] m_tdata,
  input logic                      m_tlast
);

  // No result can come out right after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // Input is taken whenever the output side takes or is empty.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    (m_tready || !m_tvalid) |-> s_tready)
    else $error("input not ready while output drains");

  // A stalled result blocks the input.
  a_block: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted while pipeline is stalled");

endmodule

bind window_median_filter wmf_checker u_wmf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
